// ===== sv/ssbp_pkg.sv =====
package ssbp_pkg;

	localparam int SEQS    = 1024;
	localparam int SEQ_W   = $clog2(SEQS);
	localparam int WORD_W  = 15;
	localparam int QDEPTH  = 4;
	localparam int QPTR_W  = $clog2(QDEPTH);

	localparam logic [7:0]  GAP_BYTE = 8'h2D;
	localparam logic [31:0] PAD_WORD = 32'h2D2D2D2D;

	localparam logic [1:0] REG_SEQ_TYPE = 2'd0;
	localparam logic [1:0] REG_CODE_C   = 2'd1;
	localparam logic [1:0] REG_CODE_G   = 2'd2;
	localparam logic [1:0] REG_CODE_T   = 2'd3;

	typedef enum logic [2:0] {
		BASE_A,
		BASE_C,
		BASE_G,
		BASE_T,
		BASE_NONE
	} base_t;

	typedef struct packed {
		logic [SEQ_W-1:0] seq;
		logic [7:0]       sym;
		logic             flush;
		base_t            base;
		logic             gap;
	} item_t;

	typedef struct packed {
		logic [5:0]        fill;
		logic [31:0]       code;
		logic [31:0]       mask;
		logic [WORD_W-1:0] wc;
	} state_t;

	typedef struct packed {
		logic       seq_type;
		logic [1:0] code_c;
		logic [1:0] code_g;
		logic [1:0] code_t;
	} cfg_t;

	localparam int STATE_W = $bits(state_t);

endpackage

// ===== sv/sequence_symbol_bit_packer_core.sv =====
// Packs symbols per sequence into 32-bit words: 16 two-bit bases in nucleotide mode, four bytes
// in protein mode, with a flush padding the open 64-symbol block and emitting the owed words.
// One symbol beat is taken per cycle unless the queue is full; a symbol completing a word yields
// it via the queue, active-item and output registers. A flush holds the back end while emitting
// its words in turn (up to 4 nucleotide, 16 protein); the four-entry queue takes beats until full.
// Per-sequence state is in a 1024-entry RAM read at pop with a one-entry write bypass; after reset
// a clearing pass zeroes it before any beat is popped; configuration writes are taken throughout.
module sequence_symbol_bit_packer_core import ssbp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [3:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	input  logic              sym_valid,
	output logic              sym_stall,
	input  logic [SEQ_W-1:0]  seq_index,
	input  logic [7:0]        symbol,
	input  logic              flush,
	output logic              word_valid,
	input  logic              word_stall,
	output logic [SEQ_W-1:0]  out_seq,
	output logic [WORD_W-1:0] word_index,
	output logic [31:0]       code_word,
	output logic [31:0]       valid_mask,
	output logic              last
);

	cfg_t  cfg_q;
	logic  push, pop, q_valid, q_full;
	item_t push_item, head;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= cfg_t'{1'b0, 2'd1, 2'd3, 2'd2};
		end else if (psel && penable && pwrite) begin
			case (paddr[3:2])
				REG_SEQ_TYPE: cfg_q.seq_type <= pwdata[0];
				REG_CODE_C:   cfg_q.code_c   <= pwdata[1:0];
				REG_CODE_G:   cfg_q.code_g   <= pwdata[1:0];
				REG_CODE_T:   cfg_q.code_t   <= pwdata[1:0];
				default:      cfg_q          <= cfg_q;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_SEQ_TYPE: prdata = {31'd0, cfg_q.seq_type};
			REG_CODE_C:   prdata = {30'd0, cfg_q.code_c};
			REG_CODE_G:   prdata = {30'd0, cfg_q.code_g};
			REG_CODE_T:   prdata = {30'd0, cfg_q.code_t};
			default:      prdata = 32'd0;
		endcase
	end

	ssbp_front u_front (
		.sym_valid (sym_valid),
		.seq_index (seq_index),
		.symbol    (symbol),
		.flush     (flush),
		.q_full    (q_full),
		.sym_stall (sym_stall),
		.push      (push),
		.item      (push_item)
	);

	ssbp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.q_valid   (q_valid),
		.q_full    (q_full),
		.head      (head)
	);

	ssbp_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.q_valid    (q_valid),
		.head       (head),
		.pop        (pop),
		.word_valid (word_valid),
		.word_stall (word_stall),
		.out_seq    (out_seq),
		.word_index (word_index),
		.code_word  (code_word),
		.valid_mask (valid_mask),
		.last       (last)
	);

endmodule

// ===== sv/ssbp_ram.sv =====
module ssbp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== sv/ssbp_front.sv =====
module ssbp_front import ssbp_pkg::*; (
	input  logic             sym_valid,
	input  logic [SEQ_W-1:0] seq_index,
	input  logic [7:0]       symbol,
	input  logic             flush,
	input  logic             q_full,
	output logic             sym_stall,
	output logic             push,
	output item_t            item
);

	always_comb begin
		item.seq   = seq_index;
		item.sym   = symbol;
		item.flush = flush;
		case (symbol)
			"A", "a": item.base = BASE_A;
			"C", "c": item.base = BASE_C;
			"G", "g": item.base = BASE_G;
			"T", "t": item.base = BASE_T;
			default:  item.base = BASE_NONE;
		endcase
		item.gap = symbol inside {"-", ".", "X", "x", "Z", "z", "B", "b", "J", "j", "?"};
	end

	assign sym_stall = q_full;
	assign push      = sym_valid && !q_full;

endmodule

// ===== sv/ssbp_queue.sv =====
module ssbp_queue import ssbp_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t push_item,
	input  logic  pop,
	output logic  q_valid,
	output logic  q_full,
	output item_t head
);

	item_t             slot_q [QDEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QPTR_W:0]   cnt_q;

	assign q_valid = cnt_q != '0;
	assign q_full  = cnt_q == (QPTR_W+1)'(QDEPTH);
	assign head    = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// ===== sv/ssbp_back.sv =====
module ssbp_back import ssbp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  cfg_t              cfg,
	input  logic              q_valid,
	input  item_t             head,
	output logic              pop,
	output logic              word_valid,
	input  logic              word_stall,
	output logic [SEQ_W-1:0]  out_seq,
	output logic [WORD_W-1:0] word_index,
	output logic [31:0]       code_word,
	output logic [31:0]       valid_mask,
	output logic              last
);

	logic             clr_q;
	logic [SEQ_W-1:0] clr_addr_q;

	item_t      a_item_q;
	logic       a_valid_q;
	logic [4:0] j_q;

	logic             byp_v_q;
	logic [SEQ_W-1:0] byp_addr_q;
	state_t           byp_data_q;

	logic [STATE_W-1:0] rdata;
	state_t             cur;
	state_t             nxt;
	logic               we;
	logic [SEQ_W-1:0]   waddr;
	logic [STATE_W-1:0] wdata;

	logic [1:0]  v;
	logic        real_b;
	logic [31:0] code_n, mask_n, code_p, sym_code, sym_mask;
	logic [31:0] nuc_pad, prot_pad, first_code, first_mask;
	logic [7:0]  pbyte;
	logic        bound, has_blk, emit, last_word, out_free, a_done;
	logic [4:0]  k;
	logic [31:0] w_code, w_mask;

	ssbp_ram #(.WIDTH(STATE_W), .DEPTH(SEQS)) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (pop),
		.raddr (head.seq),
		.rdata (rdata)
	);

	assign cur = (byp_v_q && byp_addr_q == a_item_q.seq) ? byp_data_q : state_t'(rdata);

	always_comb begin
		case (a_item_q.base)
			BASE_C:  v = cfg.code_c;
			BASE_G:  v = cfg.code_g;
			BASE_T:  v = cfg.code_t;
			default: v = 2'd0;
		endcase
		real_b = a_item_q.base != BASE_NONE;
		code_n = cur.code | (real_b ? (32'(v) << {cur.fill[3:0], 1'b0}) : 32'd0);
		mask_n = cur.mask | (real_b ? (32'(cfg.code_g) << {cur.fill[3:0], 1'b0}) : 32'd0);
		pbyte  = a_item_q.gap ? GAP_BYTE : a_item_q.sym;
		code_p = cur.code | (32'(pbyte) << {cur.fill[1:0], 3'b000});
		bound  = cfg.seq_type ? (cur.fill[1:0] == 2'd3) : (cur.fill[3:0] == 4'hF);
		sym_code = cfg.seq_type ? code_p : code_n;
		sym_mask = cfg.seq_type ? cur.mask : mask_n;

		for (int i = 0; i < 16; i++) begin
			nuc_pad[2*i +: 2] = (4'(i) >= cur.fill[3:0]) ? cfg.code_g : 2'd0;
		end
		for (int i = 0; i < 4; i++) begin
			prot_pad[8*i +: 8] = (2'(i) >= cur.fill[1:0]) ? GAP_BYTE : 8'd0;
		end
		first_code = cfg.seq_type ? (cur.code | prot_pad) : cur.code;
		first_mask = cur.mask | nuc_pad;
		has_blk = cur.fill != 6'd0;
		k = cfg.seq_type ? (5'd16 - {1'b0, cur.fill[5:2]}) : (5'd4 - {3'd0, cur.fill[5:4]});

		emit      = a_valid_q && (a_item_q.flush ? has_blk : bound);
		last_word = a_item_q.flush ? (j_q == k - 5'd1) : 1'b1;
		out_free  = !word_valid || !word_stall;
		a_done    = a_valid_q && (!emit || (out_free && last_word));
		pop       = q_valid && !clr_q && (!a_valid_q || a_done);

		if (a_item_q.flush) begin
			w_code = (j_q == 5'd0) ? first_code : (cfg.seq_type ? PAD_WORD : 32'd0);
			w_mask = (j_q == 5'd0) ? first_mask : {16{cfg.code_g}};
		end else begin
			w_code = sym_code;
			w_mask = mask_n;
		end
		if (cfg.seq_type) begin
			w_mask = 32'd0;
		end

		if (a_item_q.flush) begin
			nxt = has_blk ? state_t'{6'd0, 32'd0, 32'd0, cur.wc + WORD_W'(k)} : cur;
		end else if (bound) begin
			nxt = state_t'{cur.fill + 6'd1, 32'd0, 32'd0, cur.wc + WORD_W'(1)};
		end else begin
			nxt = state_t'{cur.fill + 6'd1, sym_code, sym_mask, cur.wc};
		end

		we    = clr_q || a_done;
		waddr = clr_q ? clr_addr_q : a_item_q.seq;
		wdata = clr_q ? '0 : STATE_W'(nxt);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= 1'b1;
			clr_addr_q <= '0;
			a_valid_q  <= 1'b0;
			j_q        <= '0;
			byp_v_q    <= 1'b0;
			word_valid <= 1'b0;
		end else begin
			if (clr_q) begin
				clr_addr_q <= clr_addr_q + 1'b1;
				if (clr_addr_q == SEQ_W'(SEQS - 1)) begin
					clr_q <= 1'b0;
				end
			end
			if (pop) begin
				a_valid_q <= 1'b1;
				j_q       <= '0;
			end else if (a_done) begin
				a_valid_q <= 1'b0;
			end else if (emit && out_free) begin
				j_q <= j_q + 5'd1;
			end
			if (clr_q) begin
				byp_v_q <= 1'b0;
			end else if (a_done) begin
				byp_v_q <= 1'b1;
			end
			if (out_free) begin
				word_valid <= emit;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			a_item_q <= head;
		end
		if (a_done) begin
			byp_addr_q <= a_item_q.seq;
			byp_data_q <= nxt;
		end
		if (out_free && emit) begin
			out_seq    <= a_item_q.seq;
			word_index <= cur.wc + WORD_W'(j_q);
			code_word  <= w_code;
			valid_mask <= w_mask;
			last       <= last_word;
		end
	end

endmodule

// ===== sv/ssbp_checker.sv =====
module ssbp_checker import ssbp_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              word_valid,
	input logic              word_stall,
	input logic [SEQ_W-1:0]  out_seq,
	input logic [WORD_W-1:0] word_index,
	input logic              last
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		word_valid && word_stall |=> word_valid)
		else $error("word beat dropped under stall");

	a_burst: assert property (@(posedge clk) disable iff (!arst_n)
		word_valid && !word_stall && !last |=> word_valid)
		else $error("flush burst broken");

	a_burst_seq: assert property (@(posedge clk) disable iff (!arst_n)
		word_valid && !word_stall && !last |=>
		out_seq == $past(out_seq) && word_index == $past(word_index) + WORD_W'(1))
		else $error("flush burst sequence or index wrong");

endmodule

bind sequence_symbol_bit_packer_core ssbp_checker u_chk (.*);

// ===== bench/packed_word_checker.sv =====
`timescale 1ns / 100ps
module packed_word_checker import ssbp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [3:0]        paddr,
	input  logic [31:0]       pwdata,
	input  logic              pready,
	input  logic              sym_valid,
	input  logic              sym_stall,
	input  logic [SEQ_W-1:0]  seq_index,
	input  logic [7:0]        symbol,
	input  logic              flush,
	input  logic              word_valid,
	input  logic              word_stall,
	input  logic [SEQ_W-1:0]  out_seq,
	input  logic [WORD_W-1:0] word_index,
	input  logic [31:0]       code_word,
	input  logic [31:0]       valid_mask,
	input  logic              last,
	output int                failures,
	output int                pending
);

	typedef struct packed {
		logic [SEQ_W-1:0]  seq;
		logic [WORD_W-1:0] idx;
		logic [31:0]       code;
		logic [31:0]       mask;
		logic              fin;
	} word_t;

	word_t owed_words[$];
	word_t fresh_words[$];
	cfg_t  cfg;

	logic [5:0]        fill_of  [SEQS];
	logic [31:0]       code_of  [SEQS];
	logic [31:0]       mask_of  [SEQS];
	logic [WORD_W-1:0] count_of [SEQS];

	function automatic bit gap_like(input logic [7:0] b);
		return b inside {"-", ".", "X", "x", "Z", "z", "B", "b", "J", "j", "?"};
	endfunction

	function automatic base_t classify(input logic [7:0] b);
		case (b)
			"A", "a": return BASE_A;
			"C", "c": return BASE_C;
			"G", "g": return BASE_G;
			"T", "t": return BASE_T;
			default:  return BASE_NONE;
		endcase
	endfunction

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		$display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
		failures++;
	endtask

	task automatic pack_symbol(input logic [SEQ_W-1:0] s, input logic [7:0] b);
		logic [5:0] f;
		logic [4:0] sh;
		logic [1:0] v;
		logic [7:0] byte_out;
		base_t      kind;
		bit         done;
		f = fill_of[s];
		if (!cfg.seq_type) begin
			sh = {f[3:0], 1'b0};
			kind = classify(b);
			case (kind)
				BASE_C:  v = cfg.code_c;
				BASE_G:  v = cfg.code_g;
				BASE_T:  v = cfg.code_t;
				default: v = 2'd0;
			endcase
			if (kind != BASE_NONE) begin
				code_of[s] |= 32'(v) << sh;
				mask_of[s] |= 32'(cfg.code_g) << sh;
			end
			done = f[3:0] == 4'hF;
		end else begin
			sh = {f[1:0], 3'b000};
			byte_out = gap_like(b) ? GAP_BYTE : b;
			code_of[s] |= 32'(byte_out) << sh;
			done = f[1:0] == 2'd3;
		end
		fill_of[s] = f + 6'd1;
		if (done) begin
			fresh_words.insert(fresh_words.size(), word_t'{s, count_of[s], code_of[s],
				cfg.seq_type ? 32'd0 : mask_of[s], 1'b0});
			count_of[s] = count_of[s] + 1'b1;
			code_of[s] = '0;
			mask_of[s] = '0;
		end
	endtask

	task automatic absorb_beat(input logic [SEQ_W-1:0] s, input logic [7:0] b, input logic fl);
		fresh_words.delete();
		if (fl) begin
			if (fill_of[s] != 0) begin
				do
					pack_symbol(s, cfg.seq_type ? GAP_BYTE : 8'("A"));
				while (fill_of[s] != 0 && fresh_words.size() < 16);
			end
		end else begin
			pack_symbol(s, b);
		end
		if (fresh_words.size() > 0) begin
			fresh_words[fresh_words.size() - 1].fin = 1'b1;
		end
		foreach (fresh_words[i])
			owed_words.insert(owed_words.size(), fresh_words[i]);
	endtask

	always @(posedge clk or negedge arst_n) begin
		word_t w;
		if (!arst_n) begin
			for (int i = 0; i < SEQS; i++) begin
				fill_of[i] = '0;
				code_of[i] = '0;
				mask_of[i] = '0;
				count_of[i] = '0;
			end
			cfg = '{seq_type: 1'b0, code_c: 2'd1, code_g: 2'd3, code_t: 2'd2};
			owed_words.delete();
			failures = 0;
		end else begin
			if (word_valid && !word_stall) begin
				if (owed_words.size() == 0) begin
					report("unexpected word", code_word, 32'd0);
				end else begin
					w = owed_words.pop_front();
					if (out_seq !== w.seq) report("out_seq", 32'(out_seq), 32'(w.seq));
					if (word_index !== w.idx) report("word_index", 32'(word_index), 32'(w.idx));
					if (code_word !== w.code) report("code_word", code_word, w.code);
					if (valid_mask !== w.mask) report("valid_mask", valid_mask, w.mask);
					if (last !== w.fin) report("last", 32'(last), 32'(w.fin));
				end
			end
			if (sym_valid && !sym_stall)
				absorb_beat(seq_index, symbol, flush);
			if (psel && penable && pwrite && pready) begin
				case (paddr[3:2])
					REG_SEQ_TYPE: cfg.seq_type = pwdata[0];
					REG_CODE_C:   cfg.code_c = pwdata[1:0];
					REG_CODE_G:   cfg.code_g = pwdata[1:0];
					REG_CODE_T:   cfg.code_t = pwdata[1:0];
					default: ;
				endcase
			end
		end
		pending = owed_words.size();
	end

endmodule

// ===== bench/sequence_symbol_bit_packer_core_test.sv =====
`timescale 1ns / 100ps
module sequence_symbol_bit_packer_core_test;
	import ssbp_pkg::*;

	localparam int IDLE_LIMIT = 6000;

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [3:0]        paddr;
	logic [31:0]       pwdata;
	logic [31:0]       prdata;
	logic              pready;
	logic              sym_valid;
	logic              sym_stall;
	logic [SEQ_W-1:0]  seq_index;
	logic [7:0]        symbol;
	logic              flush;
	logic              word_valid;
	logic              word_stall;
	logic [SEQ_W-1:0]  out_seq;
	logic [WORD_W-1:0] word_index;
	logic [31:0]       code_word;
	logic [31:0]       valid_mask;
	logic              last;
	int                failures;
	int                pending;
	int                idle_cycles;
	int                rx_tick;
	bit                hold_off;

	sequence_symbol_bit_packer_core dut (.*);

	packed_word_checker checker_i (.*);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		word_stall = 1'b0;
		rx_tick = 0;
		forever begin
			@(posedge clk);
			rx_tick++;
			if (hold_off) begin
				word_stall <= 1'b1;
				repeat (300) @(posedge clk);
				word_stall <= 1'b0;
				hold_off = 1'b0;
			end else begin
				case ((rx_tick / 64) % 4)
					0: word_stall <= 1'b0;
					1: word_stall <= ($urandom_range(0, 9) < 3);
					2: word_stall <= rx_tick[1];
					default: word_stall <= ($urandom_range(0, 9) < 7);
				endcase
			end
		end
	end

	always @(posedge clk) begin
		if ((sym_valid && !sym_stall) || (word_valid && !word_stall) || psel)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	task automatic offer(input logic [SEQ_W-1:0] s, input logic [7:0] b, input logic fl);
		sym_valid <= 1'b1;
		seq_index <= s;
		symbol <= b;
		flush <= fl;
		do @(posedge clk); while (sym_stall);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] v);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic drain();
		sym_valid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (24) @(posedge clk);
	endtask

	task automatic set_mode(input logic ty, input logic [1:0] c, input logic [1:0] g,
			input logic [1:0] t);
		drain();
		write_reg(REG_SEQ_TYPE, {31'd0, ty});
		write_reg(REG_CODE_C, {30'd0, c});
		write_reg(REG_CODE_G, {30'd0, g});
		write_reg(REG_CODE_T, {30'd0, t});
	endtask

	task automatic random_symbols(input int count);
		string letters;
		int burst_left;
		int gap;
		logic [SEQ_W-1:0] s;
		logic [7:0] b;
		letters = "ACGTacgt-.XxZzBbJj?N";
		burst_left = 0;
		for (int i = 0; i < count; i++) begin
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 12);
				gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
				if (gap > 0) begin
					sym_valid <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
			burst_left--;
			s = ($urandom_range(0, 9) < 8) ? SEQ_W'($urandom_range(0, 5))
				: SEQ_W'($urandom_range(0, SEQS - 1));
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4: b = letters[$urandom_range(0, 7)];
				5, 6:          b = letters[$urandom_range(8, 19)];
				default:       b = 8'($urandom_range(0, 255));
			endcase
			offer(s, b, $urandom_range(0, 11) == 0);
		end
	endtask

	initial begin
		string bases;
		logic [7:0] prot [10];
		hold_off = 1'b0;
		idle_cycles = 0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		sym_valid = 1'b0;
		seq_index = '0;
		symbol = '0;
		flush = 1'b0;
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		bases = "ACGTacgtN-?xAGCT";
		for (int i = 0; i < 16; i++) offer(SEQ_W'(0), bases[i], 1'b0);
		offer(SEQ_W'(SEQS - 1), "T", 1'b0);
		offer(SEQ_W'(SEQS - 1), "g", 1'b0);
		offer(SEQ_W'(SEQS - 1), 8'h00, 1'b1);
		offer(SEQ_W'(7), "C", 1'b1);
		offer(SEQ_W'(3), "C", 1'b0);
		offer(SEQ_W'(3), "G", 1'b0);

		set_mode(1'b1, 2'd1, 2'd3, 2'd2);
		prot = '{8'h00, 8'hFF, "-", ".", "X", "z", "B", "j", "?", "M"};
		foreach (prot[i]) offer(SEQ_W'(2), prot[i], 1'b0);
		offer(SEQ_W'(3), "K", 1'b0);
		offer(SEQ_W'(3), 8'hFF, 1'b1);
		offer(SEQ_W'(2), "A", 1'b1);

		set_mode(1'b0, 2'd0, 2'd0, 2'd0);
		random_symbols(65);
		set_mode(1'b0, 2'd3, 2'd3, 2'd3);
		hold_off = 1'b1;
		random_symbols(65);
		set_mode(1'b1, 2'd2, 2'd1, 2'd3);
		random_symbols(65);
		set_mode(1'b0, 2'd2, 2'd1, 2'd3);
		random_symbols(65);
		set_mode(1'b1, 2'd0, 2'd0, 2'd0);
		random_symbols(65);
		set_mode(1'b0, 2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
			2'($urandom_range(0, 3)));
		random_symbols(65);
		drain();

		if (failures == 0 && pending == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
